### rtl/blma_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blma_pkg
// Shared types and constants of the battery level moving average block.
// ----------------------------------------------------------------------------
package blma_pkg;

	localparam int MAX_WINDOW = 16;
	localparam int PTR_W      = $clog2(MAX_WINDOW);
	localparam int FILL_W     = $clog2(MAX_WINDOW + 1);
	localparam int MV_W       = 16;
	localparam int PIN_W      = 12;
	localparam int RATIO_W    = 12;
	localparam int WIN_W      = 5;
	localparam int PCT_W      = 7;
	localparam int SUM_W      = MV_W + PTR_W;
	localparam int PROD_W     = PIN_W + RATIO_W;
	localparam int NUM_W      = MV_W + PCT_W;
	localparam int DIV_N_W    = NUM_W + 1;
	localparam int DIV_D_W    = MV_W + 1;
	localparam int DIV_CNT_W  = $clog2(DIV_N_W + 1);
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [RATIO_W-1:0] RATIO_MIN   = RATIO_W'(256);
	localparam logic [RATIO_W-1:0] RATIO_RESET = RATIO_W'(512);
	localparam logic [WIN_W-1:0]   WIN_RESET   = WIN_W'(8);
	localparam logic [MV_W-1:0]    DEADBAND_RESET = MV_W'(20);
	localparam logic [MV_W-1:0]    FULL_RESET  = MV_W'(4200);
	localparam logic [MV_W-1:0]    EMPTY_RESET = MV_W'(3300);
	localparam logic [MV_W-1:0]    SPAN_DEFAULT = MV_W'(100);
	localparam logic [MV_W-1:0]    SPAN_MIN    = MV_W'(10);
	localparam logic [PCT_W-1:0]   PCT_FULL    = PCT_W'(100);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DIVIDER_RATIO = 3'd0,
		CFG_WINDOW_LENGTH = 3'd1,
		CFG_DEADBAND      = 3'd2,
		CFG_FULL_MV       = 3'd3,
		CFG_EMPTY_MV      = 3'd4
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCALE,
		ST_READ,
		ST_UPDATE,
		ST_AVG_START,
		ST_AVG_WAIT,
		ST_FILT,
		ST_PCT_PREP,
		ST_PCT_START,
		ST_PCT_WAIT,
		ST_PCT_DONE,
		ST_LOAD
	} state_t;

	typedef struct packed {
		logic capture;
		logic clear;
		logic scale;
		logic ring_read;
		logic update;
		logic avg_start;
		logic filt;
		logic pct_prep;
		logic pct_start;
		logic pct_done;
		logic load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic div_busy;
	} dp_stat_t;

endpackage

### rtl/battery_level_moving_average.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// battery_level_moving_average
// Battery voltage moving average with deadband filter and charge percent.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries cmd and pin_mv. cmd = 0 scales
//   pin_mv by the divider ratio, pushes it into the window and reports the
//   average, the deadband filtered value, a change flag and the percent.
//   cmd = 1 clears the average and filter state and reports all zeros.
//   Output channel (out_valid/out_ready) returns one result per transfer.
//   Configuration: cfg_we writes cfg_data to register cfg_idx;
//   writing the window length restarts the average. Write only while idle.
// Sequencing:
//   A sample makes two 24-step passes through the shared restoring divider
//   (average, then percent). A clear bypasses the divider and goes to load.
//   One item is in flight at a time; in_ready is high while idle.
// Reset and stalls:
//   Reset loads the register defaults and empties the window and filter.
//   A finished result sits in the output register; the next item is taken
//   meanwhile and its result holds inside until out_ready frees the register.
// ----------------------------------------------------------------------------
module battery_level_moving_average import blma_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  cmd,
	input  logic [PIN_W-1:0]      pin_mv,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [MV_W-1:0]       filtered_mv,
	output logic [MV_W-1:0]       average_mv,
	output logic                  changed,
	output logic [PCT_W-1:0]      percent
);

	dp_cmd_t  dp_cmd;
	dp_stat_t dp_stat;

	blma_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (dp_stat),
		.dp_cmd    (dp_cmd)
	);

	blma_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_idx     (cfg_idx),
		.cfg_data    (cfg_data),
		.pin_mv      (pin_mv),
		.cmd         (dp_cmd),
		.stat        (dp_stat),
		.filtered_mv (filtered_mv),
		.average_mv  (average_mv),
		.changed     (changed),
		.percent     (percent)
	);

endmodule

### rtl/blma_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blma_div
// Restoring divider, one quotient bit per cycle, shared by average and percent.
// ----------------------------------------------------------------------------
module blma_div import blma_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [DIV_N_W-1:0] dividend,
	input  logic [DIV_D_W-1:0] divisor,
	output logic               busy,
	output logic [DIV_N_W-1:0] quotient
);

	logic [DIV_D_W-1:0]   rem_q;
	logic [DIV_N_W-1:0]   quot_q;
	logic [DIV_D_W-1:0]   div_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic [DIV_D_W:0]     trial;
	logic                 fits;

	assign trial = {rem_q, quot_q[DIV_N_W-1]};
	assign fits  = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= DIV_CNT_W'(DIV_N_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - DIV_CNT_W'(1);
			if (cnt_q == DIV_CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			quot_q <= dividend;
			div_q  <= divisor;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= DIV_D_W'(trial - {1'b0, div_q});
			end else begin
				rem_q <= trial[DIV_D_W-1:0];
			end
			quot_q <= {quot_q[DIV_N_W-2:0], fits};
		end
	end

	assign busy     = busy_q;
	assign quotient = quot_q;

endmodule

### rtl/blma_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blma_datapath
// Configuration, sample ring, running sum, deadband filter and percent math.
// ----------------------------------------------------------------------------
module blma_datapath import blma_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [PIN_W-1:0]      pin_mv,
	input  dp_cmd_t               cmd,
	output dp_stat_t              stat,
	output logic [MV_W-1:0]       filtered_mv,
	output logic [MV_W-1:0]       average_mv,
	output logic                  changed,
	output logic [PCT_W-1:0]      percent
);

	logic [RATIO_W-1:0] ratio_q;
	logic [WIN_W-1:0]   window_q;
	logic [MV_W-1:0]    deadband_q;
	logic [MV_W-1:0]    full_q;
	logic [MV_W-1:0]    empty_q;

	logic [MV_W-1:0]    ring_q [MAX_WINDOW];
	logic [MV_W-1:0]    ring_rd_q;
	logic [PTR_W-1:0]   wp_q;
	logic [FILL_W-1:0]  fill_q;
	logic [SUM_W-1:0]   sum_q;
	logic [MV_W-1:0]    filt_q;
	logic               has_first_q;

	logic [PROD_W-1:0]  prod_q;
	logic [MV_W-1:0]    batt_q;
	logic [MV_W-1:0]    avg_q;
	logic               chg_q;
	logic [PCT_W-1:0]   pct_q;
	logic [NUM_W-1:0]   num_q;
	logic [MV_W-1:0]    span_q;
	logic               below_q;

	logic [MV_W-1:0]    out_filt_q;
	logic [MV_W-1:0]    out_avg_q;
	logic               out_chg_q;
	logic [PCT_W-1:0]   out_pct_q;

	logic [RATIO_W-1:0] ratio_eff;
	logic [FILL_W-1:0]  win_eff;
	logic [PROD_W-1:0]  rounded;
	logic               ring_full;
	logic [FILL_W-1:0]  wp_inc;
	logic [SUM_W-1:0]   sum_next;
	logic [MV_W-1:0]    avg_sat;
	logic [MV_W-1:0]    avg_diff;
	logic [MV_W-1:0]    span;
	logic [MV_W-1:0]    full_gap;
	logic [DIV_N_W-1:0] div_dividend;
	logic [DIV_D_W-1:0] div_divisor;
	logic [DIV_N_W-1:0] div_quot;
	logic               div_busy;

	// Clamp the programmed divider ratio and window to their usable range.
	assign ratio_eff = (ratio_q < RATIO_MIN) ? RATIO_MIN : ratio_q;

	always_comb begin
		if (window_q == '0) begin
			win_eff = FILL_W'(1);
		end else if (FILL_W'(window_q) > FILL_W'(MAX_WINDOW)) begin
			win_eff = FILL_W'(MAX_WINDOW);
		end else begin
			win_eff = FILL_W'(window_q);
		end
	end

	assign rounded   = prod_q + PROD_W'(128);
	assign ring_full = fill_q >= win_eff;
	assign wp_inc    = FILL_W'(wp_q) + FILL_W'(1);
	assign sum_next  = sum_q + SUM_W'(batt_q) - (ring_full ? SUM_W'(ring_rd_q) : '0);

	assign avg_sat  = (|div_quot[DIV_N_W-1:MV_W]) ? '1 : div_quot[MV_W-1:0];
	assign avg_diff = (avg_sat >= filt_q) ? avg_sat - filt_q : filt_q - avg_sat;

	assign full_gap = full_q - empty_q;
	always_comb begin
		if (full_q <= empty_q) begin
			span = SPAN_DEFAULT;
		end else if (full_gap < SPAN_MIN) begin
			span = SPAN_MIN;
		end else begin
			span = full_gap;
		end
	end

	// Share the divider: average first, then the rounded percent.
	always_comb begin
		if (cmd.pct_start) begin
			div_dividend = DIV_N_W'({num_q, 1'b0}) + DIV_N_W'(span_q);
			div_divisor  = {span_q, 1'b0};
		end else begin
			div_dividend = DIV_N_W'(sum_q);
			div_divisor  = DIV_D_W'(fill_q);
		end
	end

	blma_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.avg_start | cmd.pct_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.quotient (div_quot)
	);

	assign stat.div_busy = div_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ratio_q     <= RATIO_RESET;
			window_q    <= WIN_RESET;
			deadband_q  <= DEADBAND_RESET;
			full_q      <= FULL_RESET;
			empty_q     <= EMPTY_RESET;
			wp_q        <= '0;
			fill_q      <= '0;
			sum_q       <= '0;
			filt_q      <= '0;
			has_first_q <= 1'b0;
			avg_q       <= '0;
			chg_q       <= 1'b0;
			pct_q       <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx_t'(cfg_idx))
					CFG_DIVIDER_RATIO: ratio_q <= cfg_data[RATIO_W-1:0];
					CFG_WINDOW_LENGTH: begin
						window_q <= cfg_data[WIN_W-1:0];
						wp_q     <= '0;
						fill_q   <= '0;
						sum_q    <= '0;
					end
					CFG_DEADBAND: deadband_q <= cfg_data;
					CFG_FULL_MV:  full_q     <= cfg_data;
					CFG_EMPTY_MV: empty_q    <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.clear) begin
				wp_q        <= '0;
				fill_q      <= '0;
				sum_q       <= '0;
				filt_q      <= '0;
				has_first_q <= 1'b0;
				avg_q       <= '0;
				chg_q       <= 1'b0;
				pct_q       <= '0;
			end
			if (cmd.scale && FILL_W'(wp_q) >= win_eff) begin
				wp_q <= '0;
			end
			if (cmd.update) begin
				if (!ring_full) begin
					fill_q <= fill_q + FILL_W'(1);
				end
				sum_q <= sum_next;
				wp_q  <= (wp_inc == win_eff) ? '0 : wp_inc[PTR_W-1:0];
			end
			if (cmd.filt) begin
				avg_q <= avg_sat;
				if (!has_first_q || avg_diff >= deadband_q) begin
					filt_q <= avg_sat;
					chg_q  <= 1'b1;
				end else begin
					chg_q <= 1'b0;
				end
				has_first_q <= 1'b1;
			end
			if (cmd.pct_done) begin
				if (below_q) begin
					pct_q <= '0;
				end else if (div_quot > DIV_N_W'(PCT_FULL)) begin
					pct_q <= PCT_FULL;
				end else begin
					pct_q <= div_quot[PCT_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			prod_q <= PROD_W'(pin_mv) * PROD_W'(ratio_eff);
		end
		if (cmd.scale) begin
			batt_q <= rounded[PROD_W-1:8];
		end
		if (cmd.ring_read) begin
			ring_rd_q <= ring_q[wp_q];
		end
		if (cmd.update) begin
			ring_q[wp_q] <= batt_q;
		end
		if (cmd.pct_prep) begin
			below_q <= filt_q <= empty_q;
			num_q   <= NUM_W'(filt_q - empty_q) * NUM_W'(PCT_FULL);
			span_q  <= span;
		end
		if (cmd.load_out) begin
			out_filt_q <= filt_q;
			out_avg_q  <= avg_q;
			out_chg_q  <= chg_q;
			out_pct_q  <= pct_q;
		end
	end

	assign filtered_mv = out_filt_q;
	assign average_mv  = out_avg_q;
	assign changed     = out_chg_q;
	assign percent     = out_pct_q;

	a_fill_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= win_eff)
		else $error("fill count beyond window");

	a_pct_range: assert property (@(posedge clk) disable iff (!arst_n)
		pct_q <= PCT_FULL)
		else $error("percent out of range");

	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.avg_start || cmd.pct_start) |-> !div_busy)
		else $error("divider started while busy");

endmodule

### rtl/blma_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blma_ctrl
// Sequencer for one sample: scale, ring update, average, filter, percent.
// ----------------------------------------------------------------------------
module blma_ctrl import blma_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  logic     cmd,
	output logic     out_valid,
	input  logic     out_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  dp_cmd
);

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   in_xfer;
	logic   out_free;

	assign in_xfer  = in_valid && (state_q == ST_IDLE);
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = cmd ? ST_LOAD : ST_SCALE;
				end
			end
			ST_SCALE:     state_d = ST_READ;
			ST_READ:      state_d = ST_UPDATE;
			ST_UPDATE:    state_d = ST_AVG_START;
			ST_AVG_START: state_d = ST_AVG_WAIT;
			ST_AVG_WAIT: begin
				if (!stat.div_busy) begin
					state_d = ST_FILT;
				end
			end
			ST_FILT:      state_d = ST_PCT_PREP;
			ST_PCT_PREP:  state_d = ST_PCT_START;
			ST_PCT_START: state_d = ST_PCT_WAIT;
			ST_PCT_WAIT: begin
				if (!stat.div_busy) begin
					state_d = ST_PCT_DONE;
				end
			end
			ST_PCT_DONE:  state_d = ST_LOAD;
			ST_LOAD: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default:      state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		dp_cmd   = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready       = 1'b1;
				dp_cmd.capture = in_valid && !cmd;
				dp_cmd.clear   = in_valid && cmd;
			end
			ST_SCALE:     dp_cmd.scale     = 1'b1;
			ST_READ:      dp_cmd.ring_read = 1'b1;
			ST_UPDATE:    dp_cmd.update    = 1'b1;
			ST_AVG_START: dp_cmd.avg_start = 1'b1;
			ST_FILT:      dp_cmd.filt      = 1'b1;
			ST_PCT_PREP:  dp_cmd.pct_prep  = 1'b1;
			ST_PCT_START: dp_cmd.pct_start = 1'b1;
			ST_PCT_DONE:  dp_cmd.pct_done  = 1'b1;
			ST_LOAD:      dp_cmd.load_out  = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// Hold the result until its transfer, refill on load.
			if (dp_cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> !in_ready)
		else $error("second item taken while one is in flight");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.load_out |-> (!out_valid_q || out_ready))
		else $error("result overwritten before transfer");

	a_clear_fast: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && cmd) |=> state_q == ST_LOAD)
		else $error("clear did not go straight to load");

endmodule

### verif/battery_level_moving_average_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// battery_level_moving_average_test
// Self-checking bench for the battery level moving average block. A queue
// of samples and clears feeds a valid/ready driver; every accepted input is
// run through a local copy of the window, deadband filter and percent math,
// and the monitor compares each result transfer field by field with the
// oldest prediction. Register settings change between phases while idle.
// ----------------------------------------------------------------------------
module battery_level_moving_average_test;
	import blma_pkg::*;

	localparam int unsigned RUN_LIMIT  = 600_000;
	localparam int          LONG_HOLD  = 400;
	localparam int          SHOW_LIMIT = 10;

	typedef struct {
		logic             is_clear;
		logic [PIN_W-1:0] pin;
	} sample_item_t;

	typedef struct packed {
		logic [MV_W-1:0]  filtered;
		logic [MV_W-1:0]  average;
		logic             changed;
		logic [PCT_W-1:0] pct;
	} level_report_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	logic                  in_valid  = 1'b0;
	logic                  in_ready;
	logic                  cmd       = 1'b0;
	logic [PIN_W-1:0]      pin_mv    = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [MV_W-1:0]       filtered_mv;
	logic [MV_W-1:0]       average_mv;
	logic                  changed;
	logic [PCT_W-1:0]      percent;

	battery_level_moving_average DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.cmd        (cmd),
		.pin_mv     (pin_mv),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.filtered_mv(filtered_mv),
		.average_mv (average_mv),
		.changed    (changed),
		.percent    (percent)
	);

	always #10 clk = ~clk;

	// register mirror
	logic [RATIO_W-1:0] ratio_q8   = RATIO_RESET;
	logic [WIN_W-1:0]   win_len    = WIN_RESET;
	logic [MV_W-1:0]    deadband   = DEADBAND_RESET;
	logic [MV_W-1:0]    full_level = FULL_RESET;
	logic [MV_W-1:0]    empty_level = EMPTY_RESET;

	// window and filter state
	logic [MV_W-1:0]   ring_mv [MAX_WINDOW];
	logic [PTR_W-1:0]  ring_wr    = '0;
	logic [FILL_W-1:0] ring_fill  = '0;
	logic [SUM_W-1:0]  ring_sum   = '0;
	logic [MV_W-1:0]   filt_mv    = '0;
	logic              filt_valid = 1'b0;

	sample_item_t  pending_samples[$];
	level_report_t expected_reports[$];
	sample_item_t  next_sample;
	level_report_t oldest_report;

	int          mismatches    = 0;
	int          hold_requests = 0;
	int          holds_done    = 0;
	int          hold_left     = 0;
	bit          quiet         = 1'b0;
	int unsigned cycle_count   = 0;
	int          level         = 1900;

	function automatic void clear_window();
		ring_wr   = '0;
		ring_fill = '0;
		ring_sum  = '0;
	endfunction

	function automatic logic [PCT_W-1:0] charge_pct(logic [MV_W-1:0] v);
		int unsigned span, num, pct, full_u, empty_u, v_u;
		full_u  = full_level;
		empty_u = empty_level;
		v_u     = v;
		if (full_u <= empty_u) begin
			span = SPAN_DEFAULT;
		end else begin
			span = full_u - empty_u;
			if (span < SPAN_MIN)
				span = SPAN_MIN;
		end
		if (v_u <= empty_u)
			return '0;
		num = (v_u - empty_u) * 100;
		pct = (2 * num + span) / (2 * span);
		if (pct > PCT_FULL)
			pct = PCT_FULL;
		return pct[PCT_W-1:0];
	endfunction

	function automatic level_report_t track_battery_level(logic is_clear,
			logic [PIN_W-1:0] pin);
		level_report_t r;
		int unsigned   ratio, batt, win, avg, diff, filt_u;
		r = '0;
		if (is_clear) begin
			clear_window();
			filt_mv    = '0;
			filt_valid = 1'b0;
			return r;
		end
		ratio = (ratio_q8 < RATIO_MIN) ? RATIO_MIN : ratio_q8;
		batt  = (int'(pin) * ratio + 128) >> 8;
		if (batt > 65535)
			batt = 65535;
		win = (win_len == 0) ? 1 : ((win_len > MAX_WINDOW) ? MAX_WINDOW : win_len);
		if (ring_wr >= win)
			ring_wr = '0;
		if (ring_fill < win)
			ring_fill = ring_fill + 1'b1;
		else
			ring_sum = ring_sum - ring_mv[ring_wr];
		ring_mv[ring_wr] = batt[MV_W-1:0];
		ring_sum = ring_sum + batt[SUM_W-1:0];
		ring_wr  = PTR_W'((int'(ring_wr) + 1) % win);
		avg = ring_sum / ring_fill;
		if (avg > 65535)
			avg = 65535;
		filt_u = filt_mv;
		if (!filt_valid) begin
			filt_mv    = avg[MV_W-1:0];
			filt_valid = 1'b1;
			r.changed  = 1'b1;
		end else begin
			diff = (avg >= filt_u) ? avg - filt_u : filt_u - avg;
			if (diff >= deadband) begin
				filt_mv   = avg[MV_W-1:0];
				r.changed = 1'b1;
			end
		end
		r.filtered = filt_mv;
		r.average  = avg[MV_W-1:0];
		r.pct      = charge_pct(filt_mv);
		return r;
	endfunction

	// Mostly a drifting level with jitter, some full-range pins and a few clears.
	function automatic sample_item_t make_sample(int jitter);
		sample_item_t s;
		int           p;
		s.is_clear = ($urandom_range(0, 99) < 4);
		if ($urandom_range(0, 9) < 2) begin
			p = $urandom_range(0, 4095);
		end else begin
			level = level + int'($urandom_range(0, 2 * jitter)) - jitter;
			if (level < 0)
				level = 0;
			if (level > 4095)
				level = 4095;
			p = level + int'($urandom_range(0, jitter)) - jitter / 2;
			if (p < 0)
				p = 0;
			if (p > 4095)
				p = 4095;
		end
		s.pin = PIN_W'(p);
		return s;
	endfunction

	task automatic push_sample(logic is_clear, int pin);
		sample_item_t s;
		s.is_clear = is_clear;
		s.pin      = PIN_W'(pin);
		pending_samples.push_back(s);
	endtask

	task automatic wait_idle();
		do
			@(negedge clk);
		while (pending_samples.size() != 0 || in_valid || expected_reports.size() != 0);
	endtask

	task automatic write_reg(cfg_idx_t idx, int value);
		@(posedge clk);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= CFG_DATA_W'(value);
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_DIVIDER_RATIO: ratio_q8 = RATIO_W'(value);
			CFG_WINDOW_LENGTH: begin
				win_len = WIN_W'(value);
				clear_window();
			end
			CFG_DEADBAND:      deadband = MV_W'(value);
			CFG_FULL_MV:       full_level = MV_W'(value);
			CFG_EMPTY_MV:      empty_level = MV_W'(value);
			default: ;
		endcase
	endtask

	task automatic configure(int ratio, int win, int db, int full, int empty);
		write_reg(CFG_DIVIDER_RATIO, ratio);
		write_reg(CFG_WINDOW_LENGTH, win);
		write_reg(CFG_DEADBAND, db);
		write_reg(CFG_FULL_MV, full);
		write_reg(CFG_EMPTY_MV, empty);
		@(negedge clk);
	endtask

	// Pick a setting whose empty..full range sits around the scaled level.
	task automatic configure_random();
		int ratio, eff, win, db, bc, empty, full;
		ratio = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 4095)
		                                    : $urandom_range(256, 4095);
		eff   = (ratio < 256) ? 256 : ratio;
		win   = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 16);
		db    = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 120);
		level = $urandom_range(200, 3900);
		bc    = (level * eff) / 256;
		empty = bc - int'($urandom_range(0, 1500));
		if (empty < 0)
			empty = 0;
		if (empty > 65535)
			empty = 65535;
		if ($urandom_range(0, 3) != 0)
			full = empty + int'($urandom_range(0, 2500));
		else
			full = $urandom_range(0, 65535);
		if (full > 65535)
			full = 65535;
		configure(ratio, win, db, full, empty);
	endtask

	// Offer half the items, let everything drain, then offer the rest.
	task automatic run_phase(int count, int jitter, bit long_hold);
		for (int i = 0; i < count / 2; i++)
			pending_samples.push_back(make_sample(jitter));
		if (long_hold)
			hold_requests++;
		wait_idle();
		for (int i = count / 2; i < count; i++)
			pending_samples.push_back(make_sample(jitter));
		wait_idle();
		repeat (8) @(negedge clk);
	endtask

	// Driver: predict on each accepted transfer, then offer the next sample.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			cmd      <= 1'b0;
			pin_mv   <= '0;
		end else begin
			if (in_valid && in_ready)
				expected_reports.push_back(track_battery_level(cmd, pin_mv));
			if (!in_valid || in_ready) begin
				if (pending_samples.size() != 0 && (quiet || $urandom_range(0, 99) >= 9)) begin
					next_sample = pending_samples.pop_front();
					in_valid <= 1'b1;
					cmd      <= next_sample.is_clear;
					pin_mv   <= next_sample.pin;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each result transfer, and drive out_ready.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready  <= 1'b0;
			hold_left  <= 0;
			holds_done <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_reports.size() == 0) begin
					if (mismatches < SHOW_LIMIT)
						$display("unexpected result: filtered %0d average %0d changed %0d pct %0d",
							filtered_mv, average_mv, changed, percent);
					mismatches++;
				end else begin
					oldest_report = expected_reports.pop_front();
					if (oldest_report.filtered !== filtered_mv ||
							oldest_report.average !== average_mv ||
							oldest_report.changed !== changed ||
							oldest_report.pct !== percent) begin
						if (mismatches < SHOW_LIMIT)
							$display("mismatch: filtered %0d/%0d average %0d/%0d changed %0d/%0d pct %0d/%0d (exp/act)",
								oldest_report.filtered, filtered_mv,
								oldest_report.average, average_mv,
								oldest_report.changed, changed,
								oldest_report.pct, percent);
						mismatches++;
					end
				end
			end
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				out_ready <= 1'b0;
			end else if (holds_done != hold_requests) begin
				holds_done <= holds_done + 1;
				hold_left  <= LONG_HOLD;
				out_ready  <= 1'b0;
			end else begin
				out_ready <= quiet || ($urandom_range(0, 99) >= 9);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == RUN_LIMIT) begin
			$display("FAIL battery_level_moving_average");
			$finish;
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		// reset defaults: pin mV doubles, 3300..4200 maps to 0..100
		push_sample(1, 4095);
		push_sample(0, 0);
		push_sample(0, 4095);
		push_sample(0, 1650);
		push_sample(1, 0);
		push_sample(0, 2100);
		push_sample(0, 1650);
		repeat (8) push_sample(0, 1875);
		push_sample(0, 1880);
		push_sample(0, 1885);
		push_sample(0, 1890);
		push_sample(0, 4095);
		push_sample(0, 0);
		push_sample(0, 1651);
		push_sample(1, 2048);
		push_sample(0, 2048);
		push_sample(0, 1649);
		wait_idle();
		repeat (8) @(negedge clk);

		// tiny ratio, zero window, no deadband, equal full and empty
		configure(0, 0, 0, 4200, 4200);
		run_phase(60, 40, 1'b1);
		// largest ratio, oversized window, widest deadband and span
		configure(4095, 31, 65535, 65535, 0);
		run_phase(60, 200, 1'b0);
		// span narrower than the minimum
		configure(255, 16, 1, 3305, 3300);
		run_phase(60, 4, 1'b0);
		// full below empty
		configure(256, 17, 20, 1000, 3000);
		run_phase(60, 60, 1'b0);
		// single-sample window, all-zero levels
		configure(4095, 1, 65535, 0, 0);
		run_phase(60, 300, 1'b0);

		for (int p = 0; p < 8; p++) begin
			quiet = (p == 3);
			configure_random();
			run_phase(90, $urandom_range(2, 150), p == 5);
		end
		quiet = 1'b0;

		wait_idle();
		repeat (100) @(negedge clk);
		if (mismatches == 0 && expected_reports.size() == 0)
			$display("PASS battery_level_moving_average");
		else
			$display("FAIL battery_level_moving_average");
		$finish;
	end

endmodule
